>>> hw/rtl/edf_ready_queue_unit_macros.svh
// assertion macros for the checker file of the edf ready queue
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef EDF_READY_QUEUE_UNIT_MACROS_SVH
`define EDF_READY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define EDFQ_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("edfq check failed");

// next-cycle implication, disabled during reset
`define EDFQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("edfq check failed");

`endif

>>> hw/rtl/edfq_pkg.sv
// shared types, constants and helpers of the edf ready queue
// no dependencies
package edfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LATEST = 2'd2,
      ACT_EARLY  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FOP_NONE,
      FOP_INSERT,
      FOP_REMOVE,
      FOP_WR_LATE,
      FOP_WR_EARLY
   } fop_type;

   typedef struct packed {
      logic [7:0]         tag;
      logic [23:0]        due;
      logic [23:0]        arrival;
      logic [23:0]        cost;
      logic signed [31:0] late;
      logic signed [31:0] early;
   } entry_type;

   typedef struct packed {
      fop_type            op;
      logic [IDX_W-1:0]   addr;
      entry_type          entry;
      logic signed [31:0] word;
   } file_cmd_type;

   // clamp a widened time sum to the signed 32-bit range
   function automatic logic signed [31:0] sat_time(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/edf_ready_queue_unit.sv
// EDF ready queue: up to QUEUE_DEPTH jobs sorted by deadline, then release
// time. One transaction in at a time; req_ready is low while an action runs.
// An insert searches for its position, then opens a slot there; a remove
// closes the head; a latest-start pass runs a tail-to-head update walk then
// a head-to-tail report walk; an early-start pass runs one head-to-tail walk.
// A full insert or an action on an empty queue goes straight to its result.
// Results wait while rsp_ready is held low. Entries are read through the
// single entry read port.
// depends on edfq_pkg and edfq_entry_file
module edf_ready_queue_unit
   import edfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_task_tag,
   input  logic [23:0]        req_due_tick,
   input  logic [23:0]        req_arrival_tick,
   input  logic [23:0]        req_cost,
   input  logic signed [31:0] req_latest_start_in,
   input  logic signed [31:0] req_early_start_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_result_tag,
   output logic signed [31:0] rsp_time_value,
   output logic [4:0]         rsp_entry_count,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_INSERT,
      S_RESP,
      S_LS_CALC,
      S_EMIT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   ptr_ff;
   action_type         act_ff;
   status_type         stat_ff;
   entry_type          new_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] acc_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_tag_ff;
   logic signed [31:0] rsp_time_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   status_type         rsp_status_ff;
   logic               rsp_last_ff;

   file_cmd_type       cmd;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd;
   logic               accept;
   logic               out_free;
   logic               rsp_load;
   logic               go_on;
   logic signed [31:0] cand;
   logic signed [31:0] emit_val;
   logic [CNT_W-1:0]   ptr_prev;
   logic [CNT_W-1:0]   count_last;

   edfq_entry_file u_file (
      .clock    (clock),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .rd_entry (rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == S_RESP || state_ff == S_EMIT);
   assign ptr_prev  = ptr_ff - CNT_W'(1);
   assign count_last = count_ff - CNT_W'(1);

   // search keeps walking past earlier deadlines and older equals
   assign go_on = (ptr_ff < count_ff) && (rd.due <= new_ff.due) &&
                  !((rd.due == new_ff.due) && (rd.arrival > new_ff.arrival));

   // subtractor: later minimum minus cost for the latest-start walk
   assign cand = sat_time(34'(min_ff) - $signed({10'd0, rd.cost}));

   // value reported in a pass
   always_comb begin
      if (act_ff == ACT_LATEST) begin
         emit_val = rd.late;
      end else if (ptr_ff == '0) begin
         emit_val = rd.early;
      end else begin
         emit_val = acc_ff;
      end
   end

   // read address and storage command
   always_comb begin
      cmd       = '0;
      cmd.op    = FOP_NONE;
      cmd.entry = new_ff;
      rd_addr   = ptr_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            rd_addr = count_last[IDX_W-1:0];
            if (accept && action_type'(req_action) == ACT_REMOVE && count_ff != '0) begin
               cmd.op = FOP_REMOVE;
            end
         end
         S_INSERT: begin
            cmd.op   = FOP_INSERT;
            cmd.addr = ptr_ff[IDX_W-1:0];
         end
         S_RESP: begin
            rd_addr = '0;
         end
         S_LS_CALC: begin
            rd_addr = ptr_prev[IDX_W-1:0];
            if (ptr_ff != '0) begin
               cmd.op   = FOP_WR_LATE;
               cmd.addr = ptr_prev[IDX_W-1:0];
               cmd.word = (cand < rd.late) ? cand : rd.late;
            end
         end
         S_EMIT: begin
            if (out_free && act_ff == ACT_EARLY && ptr_ff != '0) begin
               cmd.op   = FOP_WR_EARLY;
               cmd.addr = ptr_ff[IDX_W-1:0];
               cmd.word = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  act_ff         <= action_type'(req_action);
                  new_ff.tag     <= req_task_tag;
                  new_ff.due     <= req_due_tick;
                  new_ff.arrival <= req_arrival_tick;
                  new_ff.cost    <= req_cost;
                  new_ff.late    <= req_latest_start_in;
                  new_ff.early   <= req_early_start_in;
                  min_ff         <= rd.late;
                  ptr_ff         <= (action_type'(req_action) == ACT_LATEST) ? count_last : '0;
                  case (action_type'(req_action))
                     ACT_INSERT: begin
                        if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                           stat_ff  <= STATUS_FULL;
                           state_ff <= S_RESP;
                        end else begin
                           stat_ff  <= STATUS_OK;
                           state_ff <= S_SEARCH;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           stat_ff  <= STATUS_EMPTY;
                           state_ff <= S_RESP;
                        end else begin
                           stat_ff <= STATUS_OK;
                           if (action_type'(req_action) == ACT_REMOVE) begin
                              count_ff <= count_last;
                              state_ff <= S_RESP;
                           end else if (action_type'(req_action) == ACT_LATEST) begin
                              state_ff <= S_LS_CALC;
                           end else begin
                              state_ff <= S_EMIT;
                           end
                        end
                     end
                  endcase
               end
            end
            S_SEARCH: begin
               if (go_on) begin
                  ptr_ff <= ptr_ff + CNT_W'(1);
               end else begin
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_tag_ff    <= (count_ff == '0) ? 8'd0 : rd.tag;
                  rsp_time_ff   <= '0;
                  rsp_count_ff  <= count_ff;
                  rsp_status_ff <= stat_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_LS_CALC: begin
               if (ptr_ff == '0) begin
                  state_ff <= S_EMIT;
               end else begin
                  if (rd.late < min_ff) begin
                     min_ff <= rd.late;
                  end
                  ptr_ff <= ptr_prev;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_tag_ff    <= rd.tag;
                  rsp_time_ff   <= emit_val;
                  rsp_count_ff  <= count_ff;
                  rsp_status_ff <= STATUS_OK;
                  rsp_last_ff   <= (ptr_ff == count_last);
                  acc_ff        <= sat_time(34'(emit_val) + $signed({10'd0, rd.cost}));
                  ptr_ff        <= ptr_ff + CNT_W'(1);
                  if (ptr_ff == count_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_tag  = rsp_tag_ff;
   assign rsp_time_value  = rsp_time_ff;
   assign rsp_entry_count = COUNT_OUT_W'(rsp_count_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> hw/rtl/edfq_entry_file.sv
// entry storage of the edf ready queue: shifting register file, one read port
// depends on edfq_pkg
module edfq_entry_file
   import edfq_pkg::*;
(
   input  logic             clock,
   input  file_cmd_type     cmd,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry
);

   entry_type entry_ff [QUEUE_DEPTH];

   // single read port
   assign rd_entry = entry_ff[rd_addr];

   // open a slot, close the head, or rewrite one time word
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (cmd.op)
            FOP_INSERT: begin
               if (IDX_W'(i) == cmd.addr) begin
                  entry_ff[i] <= cmd.entry;
               end else if (i > 0 && IDX_W'(i) > cmd.addr) begin
                  entry_ff[i] <= entry_ff[(i > 0) ? i - 1 : 0];
               end
            end
            FOP_REMOVE: begin
               if (i < QUEUE_DEPTH - 1) begin
                  entry_ff[i] <= entry_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               end
            end
            FOP_WR_LATE: begin
               if (IDX_W'(i) == cmd.addr) begin
                  entry_ff[i].late <= cmd.word;
               end
            end
            FOP_WR_EARLY: begin
               if (IDX_W'(i) == cmd.addr) begin
                  entry_ff[i].early <= cmd.word;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/edfq_checker.sv
// port-level checks of the edf ready queue, bound to the top level
// depends on edfq_pkg and edf_ready_queue_unit_macros.svh
`include "edf_ready_queue_unit_macros.svh"

module edfq_checker
   import edfq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_action,
   input logic [7:0]         req_task_tag,
   input logic [23:0]        req_due_tick,
   input logic [23:0]        req_arrival_tick,
   input logic [23:0]        req_cost,
   input logic signed [31:0] req_latest_start_in,
   input logic signed [31:0] req_early_start_in,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_result_tag,
   input logic signed [31:0] rsp_time_value,
   input logic [4:0]         rsp_entry_count,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   // a stalled result transaction holds
   `EDFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_time_value) && $stable(rsp_result_tag))

   // a dropped insert only happens on a full queue and ends the action
   `EDFQ_ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_entry_count == COUNT_OUT_W'(QUEUE_DEPTH) && rsp_last)

   // an empty-queue result carries nothing
   `EDFQ_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_entry_count == '0 && rsp_result_tag == '0 && rsp_time_value == '0 && rsp_last)

   // only pass results may continue, and those are always ok
   `EDFQ_ASSERT_IMPLY(a_mid_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == STATUS_OK && rsp_entry_count != '0)

endmodule

bind edf_ready_queue_unit edfq_checker u_edfq_checker (.*);
